[sv/cfnc_pkg.sv]
// Package: shared constants, types and state encoding for the chroma folder.
package cfnc_pkg;

  localparam int NumBins    = 64;
  localparam int Classes    = 12;
  localparam int FirstClass = 9;
  localparam int SumW       = 22;
  localparam int ValW       = 16;
  localparam int BinCntW    = $clog2(NumBins);
  localparam int ClsW       = 4;
  localparam int DivSteps   = ValW + 1;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [ValW-1:0] ValMax = {ValW{1'b1}};
  localparam logic [ValW-1:0] MinSumReset = 16'd66;
  // floor(2^20 / 27), reciprocal for the clarity division
  localparam logic [ValW-1:0] Recip27 = 16'd38836;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_TOTAL,
    ST_DIV,
    ST_STAT,
    ST_CLAR,
    ST_OUT
  } state_t;

endpackage

[sv/cfnc_if.sv]
// Interfaces: valid/ready request channels for input, result and configuration.
interface cfnc_in_if;
  logic                        valid;
  logic                        ready;
  logic [cfnc_pkg::ValW-1:0]   bin_value;
  logic                        last_bin;
  modport source (output valid, output bin_value, output last_bin, input ready);
  modport sink   (input valid, input bin_value, input last_bin, output ready);
endinterface

interface cfnc_out_if;
  logic                        valid;
  logic                        ready;
  logic [cfnc_pkg::ClsW-1:0]   pitch_class;
  logic [cfnc_pkg::ValW-1:0]   class_value;
  logic [cfnc_pkg::ValW-1:0]   clarity;
  logic                        last_result;
  modport source (output valid, output pitch_class, output class_value,
                  output clarity, output last_result, input ready);
  modport sink   (input valid, input pitch_class, input class_value,
                  input clarity, input last_result, output ready);
endinterface

interface cfnc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cfnc_pkg::ValW-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/chroma_fold_normalize_clarity.sv]
// Top level: chroma folder with sum normalization and key clarity.
// Usage:
//   in_ch carries one semitone bin per request (bin_value Q0.16, last_bin).
//   Bin i of a frame adds into pitch class (9+i) mod 12; bin 63 ends a
//   frame even without last_bin.
//   cfg_ch writes min_sum (reset 66); write only while the block is idle.
//   out_ch delivers twelve requests per frame, class 0 first, all carrying
//   the frame clarity; last_result marks the twelfth.
// Timing:
//   Each bin adds into its class sum; the final bin also starts a sequence:
//   totalling the classes, one division per class on the shared restoring
//   divider (one quotient bit a cycle; no division when the frame passes
//   through unnormalized), squared deviations and clarity on the shared
//   multiplier, then one result a cycle while out_ready is high. in_ready
//   stays low from the final bin until the last result has been accepted.
// Reset: accumulators, bin counter and sequencer clear; min_sum = 66.
// Stall: the output register holds while out_ready is low; the sequencer
//   waits and nothing is dropped.
module chroma_fold_normalize_clarity (
  input logic       clk,
  input logic       rst_n,
  cfnc_in_if.sink   in_ch,
  cfnc_out_if.source out_ch,
  cfnc_cfg_if.sink  cfg_ch
);

  cfnc_pkg::state_t state_r, state_nxt;

  logic [cfnc_pkg::SumW-1:0]    sums_r [cfnc_pkg::Classes];
  logic [cfnc_pkg::ValW-1:0]    scaled_r [cfnc_pkg::Classes];
  logic [cfnc_pkg::BinCntW-1:0] bin_cnt_r;
  logic [cfnc_pkg::ClsW-1:0]    cls_r;
  logic [cfnc_pkg::ClsW-1:0]    k_r, k_nxt;
  logic [cfnc_pkg::ValW-1:0]    min_sum_r;
  logic [cfnc_pkg::SumW-1:0]    total_r;
  logic                         norm_r;
  // divider
  logic [4:0]                   dstep_r, dstep_nxt;
  logic [cfnc_pkg::SumW-1:0]    rem_r;
  logic [cfnc_pkg::DivSteps-1:0] dvd_r;
  logic [cfnc_pkg::ValW-1:0]    quo_r;
  // statistics
  logic [cfnc_pkg::ValW-1:0]    peak_r;
  logic [40:0]                  sq_r;
  logic [1:0]                   cstep_r;
  logic [56:0]                  prod_r;
  logic [cfnc_pkg::ValW-1:0]    clar_r;

  logic in_acc, out_acc, frame_end;
  assign in_ch.ready  = (state_r == cfnc_pkg::ST_ACC);
  assign cfg_ch.ready = 1'b1;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign frame_end = in_ch.last_bin ||
                     (bin_cnt_r == cfnc_pkg::BinCntW'(cfnc_pkg::NumBins - 1));

  logic [cfnc_pkg::SumW:0] acc_sum;
  assign acc_sum = {1'b0, sums_r[cls_r]} + (cfnc_pkg::SumW+1)'(in_ch.bin_value);

  // Next class index for preloading the divider.
  logic [cfnc_pkg::ClsW-1:0] k_inc;
  assign k_inc = (k_r == cfnc_pkg::ClsW'(cfnc_pkg::Classes - 1)) ? '0 : k_r + 1'b1;

  // Shared restoring divider step: remainder shifted with next dividend bit.
  // The quotient never exceeds 2^16, so the remainder starts preloaded with
  // the class sum shifted right by one and only 17 steps remain.
  logic [cfnc_pkg::SumW:0]       rem_sh;
  logic                          rem_ge;
  logic [cfnc_pkg::DivSteps-1:0] q_fin;
  logic                          div_last;
  assign rem_sh   = {rem_r, dvd_r[cfnc_pkg::DivSteps-1]};
  assign rem_ge   = rem_sh >= {1'b0, total_r};
  assign q_fin    = {quo_r, rem_ge};
  assign div_last = (dstep_r == 5'(cfnc_pkg::DivSteps - 1));

  // Shared multiplier: deviation squared, then peak by sum of squares in
  // two halves.
  logic [cfnc_pkg::ValW-1:0] v_cur;
  logic [19:0] t12;
  logic [19:0] dev;
  assign v_cur = scaled_r[k_r];
  assign t12   = 20'(v_cur) * 20'd12;
  assign dev   = (t12 >= 20'd65536) ? t12 - 20'd65536 : 20'd65536 - t12;

  logic [20:0] mul_a;
  logic [19:0] mul_b;
  logic [40:0] mul_p;
  always_comb begin
    if (state_r == cfnc_pkg::ST_STAT) begin
      mul_a = 21'(dev);
      mul_b = dev;
    end else if (cstep_r == 2'd0) begin
      mul_a = 21'(sq_r[19:0]);
      mul_b = 20'(peak_r);
    end else begin
      mul_a = sq_r[40:20];
      mul_b = 20'(peak_r);
    end
  end
  assign mul_p = 41'(mul_a) * 41'(mul_b);

  // extra = prod / (864 * 2^32) = (prod >> 37) / 27 ; value < 2^20 / 27.
  // The reciprocal underestimates by at most one; fix up with the remainder.
  logic [19:0] hi;
  logic [35:0] hi_recip;
  logic [15:0] extra;
  logic [17:0] clar_sum;
  assign hi = prod_r[56:37];
  assign hi_recip = 36'(hi) * 36'(cfnc_pkg::Recip27);
  assign extra = hi_recip[35:20];
  logic [19:0] chk;
  logic [15:0] extra_fix;
  assign chk = hi - (20'(extra) * 20'd27);
  assign extra_fix = (chk >= 20'd27) ? extra + 16'd1 : extra;
  assign clar_sum = 18'(peak_r) + 18'(extra_fix);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    dstep_nxt = dstep_r;
    case (state_r)
      cfnc_pkg::ST_ACC: begin
        if (in_acc && frame_end) begin
          state_nxt = cfnc_pkg::ST_TOTAL;
          k_nxt = '0;
        end
      end
      cfnc_pkg::ST_TOTAL: begin
        if (k_r == cfnc_pkg::ClsW'(cfnc_pkg::Classes - 1)) begin
          state_nxt = cfnc_pkg::ST_DIV;
          k_nxt = '0;
          dstep_nxt = '0;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      cfnc_pkg::ST_DIV: begin
        if (!norm_r || div_last) begin
          dstep_nxt = '0;
          if (k_r == cfnc_pkg::ClsW'(cfnc_pkg::Classes - 1)) begin
            state_nxt = cfnc_pkg::ST_STAT;
            k_nxt = '0;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else begin
          dstep_nxt = dstep_r + 1'b1;
        end
      end
      cfnc_pkg::ST_STAT: begin
        if (k_r == cfnc_pkg::ClsW'(cfnc_pkg::Classes - 1)) begin
          state_nxt = cfnc_pkg::ST_CLAR;
          k_nxt = '0;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      cfnc_pkg::ST_CLAR: begin
        if (cstep_r == 2'd3) state_nxt = cfnc_pkg::ST_OUT;
      end
      cfnc_pkg::ST_OUT: begin
        if (!out_ch.valid || out_acc) begin
          if (k_r == cfnc_pkg::ClsW'(cfnc_pkg::Classes)) begin
            state_nxt = cfnc_pkg::ST_ACC;
            k_nxt = '0;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: state_nxt = cfnc_pkg::ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfnc_pkg::ST_ACC;
      k_r     <= '0;
      dstep_r <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      dstep_r <= dstep_nxt;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) min_sum_r <= cfnc_pkg::MinSumReset;
    else if (cfg_ch.valid && cfg_ch.ready) min_sum_r <= cfg_ch.data;
  end

  // Accumulate bins; clear sums once the frame has been taken apart.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r <= '0;
      cls_r     <= cfnc_pkg::ClsW'(cfnc_pkg::FirstClass);
      for (int i = 0; i < cfnc_pkg::Classes; i++) sums_r[i] <= '0;
    end else if (in_acc) begin
      sums_r[cls_r] <= acc_sum[cfnc_pkg::SumW] ? cfnc_pkg::SumMax
                                               : acc_sum[cfnc_pkg::SumW-1:0];
      if (frame_end) begin
        bin_cnt_r <= '0;
        cls_r     <= cfnc_pkg::ClsW'(cfnc_pkg::FirstClass);
      end else begin
        bin_cnt_r <= bin_cnt_r + 1'b1;
        cls_r <= (cls_r == cfnc_pkg::ClsW'(cfnc_pkg::Classes - 1)) ? '0 : cls_r + 1'b1;
      end
    end else if (state_r == cfnc_pkg::ST_STAT && k_r == '0) begin
      for (int i = 0; i < cfnc_pkg::Classes; i++) sums_r[i] <= '0;
    end
  end

  // Datapath of the sequencer.
  logic [cfnc_pkg::SumW:0]   tot_add;
  logic [cfnc_pkg::SumW-1:0] tot_sat;
  assign tot_add = {1'b0, total_r} + {1'b0, sums_r[k_r]};
  assign tot_sat = tot_add[cfnc_pkg::SumW] ? cfnc_pkg::SumMax
                                           : tot_add[cfnc_pkg::SumW-1:0];

  always_ff @(posedge clk) begin
    case (state_r)
      cfnc_pkg::ST_ACC: begin
        total_r <= '0;
      end
      cfnc_pkg::ST_TOTAL: begin
        total_r <= tot_sat;
        if (k_r == cfnc_pkg::ClsW'(cfnc_pkg::Classes - 1)) begin
          // preload the divider with class 0
          norm_r <= tot_sat > cfnc_pkg::SumW'(min_sum_r);
          rem_r  <= {1'b0, sums_r[0][cfnc_pkg::SumW-1:1]};
          dvd_r  <= {sums_r[0][0], {cfnc_pkg::ValW{1'b0}}};
          quo_r  <= '0;
        end
      end
      cfnc_pkg::ST_DIV: begin
        if (!norm_r) begin
          scaled_r[k_r] <= (sums_r[k_r] > cfnc_pkg::SumW'(cfnc_pkg::ValMax))
                           ? cfnc_pkg::ValMax : sums_r[k_r][cfnc_pkg::ValW-1:0];
        end else if (div_last) begin
          // last quotient bit: saturate and preload the next class
          scaled_r[k_r] <= q_fin[cfnc_pkg::ValW] ? cfnc_pkg::ValMax
                                                 : q_fin[cfnc_pkg::ValW-1:0];
          rem_r <= {1'b0, sums_r[k_inc][cfnc_pkg::SumW-1:1]};
          dvd_r <= {sums_r[k_inc][0], {cfnc_pkg::ValW{1'b0}}};
          quo_r <= '0;
        end else begin
          rem_r <= rem_ge ? cfnc_pkg::SumW'(rem_sh - {1'b0, total_r})
                          : rem_sh[cfnc_pkg::SumW-1:0];
          dvd_r <= dvd_r << 1;
          quo_r <= {quo_r[cfnc_pkg::ValW-2:0], rem_ge};
        end
        peak_r  <= '0;
        sq_r    <= '0;
        cstep_r <= '0;
      end
      cfnc_pkg::ST_STAT: begin
        if (v_cur > peak_r) peak_r <= v_cur;
        sq_r <= sq_r + mul_p;
      end
      cfnc_pkg::ST_CLAR: begin
        cstep_r <= cstep_r + 1'b1;
        if (cstep_r == 2'd0) prod_r <= 57'(mul_p);
        if (cstep_r == 2'd1) prod_r <= prod_r + (57'(mul_p) << 20);
        if (cstep_r == 2'd2) clar_r <= (clar_sum > 18'(cfnc_pkg::ValMax))
                                       ? cfnc_pkg::ValMax : clar_sum[15:0];
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ch.valid <= 1'b0;
    end else if (state_r == cfnc_pkg::ST_OUT && (!out_ch.valid || out_acc)) begin
      out_ch.valid <= (k_r != cfnc_pkg::ClsW'(cfnc_pkg::Classes));
    end
  end
  always_ff @(posedge clk) begin
    if (state_r == cfnc_pkg::ST_OUT && (!out_ch.valid || out_acc) &&
        k_r != cfnc_pkg::ClsW'(cfnc_pkg::Classes)) begin
      out_ch.pitch_class <= k_r;
      out_ch.class_value <= scaled_r[k_r];
      out_ch.clarity     <= clar_r;
      out_ch.last_result <= (k_r == cfnc_pkg::ClsW'(cfnc_pkg::Classes - 1));
    end
  end

  a_ready_acc : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid || state_r == cfnc_pkg::ST_ACC)
    else $error("input ready outside accumulate");
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.class_value))
    else $error("result changed under stall");
  a_cls : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.pitch_class < cfnc_pkg::ClsW'(cfnc_pkg::Classes))
    else $error("bad pitch class");
  a_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_result |->
      out_ch.pitch_class == cfnc_pkg::ClsW'(cfnc_pkg::Classes - 1))
    else $error("last flag misplaced");

endmodule

[tb/tb_if.sv]
// Testbench package: the expected chroma request record.
package tb_chroma_pkg;

  typedef struct packed {
    logic [cfnc_pkg::ClsW-1:0] pitch_class;
    logic [cfnc_pkg::ValW-1:0] class_value;
    logic [cfnc_pkg::ValW-1:0] clarity;
    logic                      last_result;
  } chroma_res_t;
endpackage

[tb/tb.sv]
// Testbench top: drives frames of semitone bins and checks every chroma request.
module tb;

  localparam int CycleLimit     = 2000000;
  localparam int DrainCycles    = 400;
  localparam int HoldOffCycles  = 1500;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cfnc_in_if  in_ch ();
  cfnc_out_if out_ch ();
  cfnc_cfg_if cfg_ch ();

  chroma_fold_normalize_clarity i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  // Predictor state: class accumulators, bin position and threshold.
  logic [cfnc_pkg::SumW-1:0]    fold_sums [cfnc_pkg::Classes];
  logic [cfnc_pkg::BinCntW-1:0] fold_pos;
  logic [cfnc_pkg::ValW-1:0]    fold_min_sum;

  // Expected chroma requests, oldest first.
  tb_chroma_pkg::chroma_res_t chroma_expect_q [$];

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct;    // sender idle chance in percent
  int recv_stall_pct;   // receiver stall chance in percent
  bit hold_off_go;      // raised by a test to start a long hold-off
  bit hold_off_on;      // receiver holds off while set
  int item_count;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // Key clarity of twelve class values: M + floor(M*S / (864*2^32)), capped.
  function automatic logic [cfnc_pkg::ValW-1:0] frame_clarity(
      input logic [cfnc_pkg::ValW-1:0] v [cfnc_pkg::Classes]);
    logic [63:0] peak;
    logic [63:0] sq;
    logic [63:0] t;
    logic [63:0] d;
    logic [127:0] prod;
    logic [127:0] total;
    peak = 0;
    sq   = 0;
    for (int k = 0; k < cfnc_pkg::Classes; k++) begin
      t = 64'(v[k]) * 12;
      d = (t >= 65536) ? t - 65536 : 65536 - t;
      if (64'(v[k]) > peak) peak = 64'(v[k]);
      sq += d * d;
    end
    prod  = 128'(peak) * 128'(sq);
    total = 128'(peak) + prod / (128'(864) << 32);
    return (total > 65535) ? cfnc_pkg::ValMax : total[cfnc_pkg::ValW-1:0];
  endfunction

  // Fold one accepted bin; at frame end, queue the twelve chroma requests.
  task automatic fold_bin(input logic [cfnc_pkg::ValW-1:0] bin, input logic last);
    logic [31:0]               cls;
    logic [31:0]               acc;
    logic [31:0]               total;
    logic [63:0]               q;
    logic [cfnc_pkg::ValW-1:0] vals [cfnc_pkg::Classes];
    logic [cfnc_pkg::ValW-1:0] clar;
    tb_chroma_pkg::chroma_res_t r;
    cls = (cfnc_pkg::FirstClass + fold_pos) % cfnc_pkg::Classes;
    acc = 32'(fold_sums[cls]) + 32'(bin);
    fold_sums[cls] = (acc > 32'(cfnc_pkg::SumMax)) ? cfnc_pkg::SumMax
                                                   : acc[cfnc_pkg::SumW-1:0];
    if (!last && int'(fold_pos) + 1 < cfnc_pkg::NumBins) begin
      fold_pos++;
      return;
    end
    total = 0;
    for (int k = 0; k < cfnc_pkg::Classes; k++) total += 32'(fold_sums[k]);
    if (total > 32'(cfnc_pkg::SumMax)) total = 32'(cfnc_pkg::SumMax);
    for (int k = 0; k < cfnc_pkg::Classes; k++) begin
      if (total > 32'(fold_min_sum)) begin
        q = (64'(fold_sums[k]) << 16) / 64'(total);
        vals[k] = (q > 65535) ? cfnc_pkg::ValMax : q[cfnc_pkg::ValW-1:0];
      end else begin
        vals[k] = (fold_sums[k] > 65535) ? cfnc_pkg::ValMax
                                         : fold_sums[k][cfnc_pkg::ValW-1:0];
      end
    end
    clar = frame_clarity(vals);
    for (int k = 0; k < cfnc_pkg::Classes; k++) begin
      r.pitch_class = cfnc_pkg::ClsW'(k);
      r.class_value = vals[k];
      r.clarity     = clar;
      r.last_result = (k == cfnc_pkg::Classes - 1);
      chroma_expect_q.push_back(r);
      fold_sums[k] = '0;
    end
    fold_pos = '0;
  endtask

  // Send one bin request; drop valid only while idling, hold it until accepted.
  task automatic send_bin(input logic [cfnc_pkg::ValW-1:0] bin, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.bin_value <= bin;
    in_ch.last_bin  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    fold_bin(bin, last);
    item_count++;
  endtask

  // Wait for all expected requests, then let the sequencer settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (chroma_expect_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_min_sum(input logic [cfnc_pkg::ValW-1:0] value);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    fold_min_sum = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // Send a frame of n bins; the last one carries last_bin unless drop_flag.
  task automatic send_frame(input int n, input int max_val, input bit drop_flag);
    for (int i = 0; i < n; i++)
      send_bin(cfnc_pkg::ValW'($urandom_range(max_val)), (i == n - 1) && !drop_flag);
  endtask

  // Long receiver hold-off, counted in cycles here.
  always begin
    @(posedge hold_off_go);
    hold_off_on <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_off_on <= 1'b0;
  end

  // Receiver: stall at random, hold off when asked, check each request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (chroma_expect_q.size() == 0) begin
          report_mismatch("unexpected request, pitch_class", out_ch.pitch_class, -1);
        end else begin
          tb_chroma_pkg::chroma_res_t w;
          w = chroma_expect_q.pop_front();
          if (out_ch.pitch_class !== w.pitch_class)
            report_mismatch("pitch_class", out_ch.pitch_class, w.pitch_class);
          if (out_ch.class_value !== w.class_value)
            report_mismatch("class_value", out_ch.class_value, w.class_value);
          if (out_ch.clarity !== w.clarity)
            report_mismatch("clarity", out_ch.clarity, w.clarity);
          if (out_ch.last_result !== w.last_result)
            report_mismatch("last_result", out_ch.last_result, w.last_result);
        end
      end
      if (hold_off_on) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Directed: extremes of bins, short and single-bin frames.
  task automatic test_directed();
    send_bin(16'hFFFF, 1'b1);                 // single bin, class A takes all
    send_bin(16'h0000, 1'b1);                 // all-zero frame, passthrough
    for (int i = 0; i < 12; i++) send_bin(16'hFFFF, i == 11);  // flat profile
    send_bin(16'd40, 1'b0);                   // small total, below the reset min_sum
    send_bin(16'd20, 1'b1);
    send_bin(16'd1, 1'b0);
    send_bin(16'hAAAA, 1'b0);
    send_bin(16'h5555, 1'b1);
  endtask

  // Overlong frame: 64 random bins up to full scale end the frame without last_bin.
  task automatic test_overlong();
    send_frame(cfnc_pkg::NumBins, 65535, 1'b1);
    send_frame(cfnc_pkg::NumBins + 5, 65535, 1'b0);     // wraps into a next frame
  endtask

  // Random frames: mostly short frames of random length and magnitude.
  task automatic test_random(input int n_items);
    int start;
    int len;
    int mx;
    start = item_count;
    while (item_count - start < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(cfnc_pkg::NumBins, 13)
                                     : $urandom_range(12, 1);
      case ($urandom_range(3))
        0: mx = 100;
        1: mx = 2000;
        default: mx = 65535;
      endcase
      send_frame(len, mx, 1'b0);
    end
  endtask

  // Pressure: long receiver hold-off while bins keep coming.
  task automatic test_backpressure();
    hold_off_go   = 1'b1;
    send_idle_pct = 0;
    for (int f = 0; f < 4; f++) send_frame(6, 65535, 1'b0);
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.bin_value  <= '0;
    in_ch.last_bin   <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.data      <= '0;
    item_count       = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    fold_min_sum     = cfnc_pkg::MinSumReset;
    fold_pos         = '0;
    for (int k = 0; k < cfnc_pkg::Classes; k++) fold_sums[k] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_overlong();
    write_min_sum(16'hFFFF);                  // largest threshold: passthrough for totals up to 65535
    test_directed();
    write_min_sum(16'h0000);                  // zero threshold: normalize any nonzero total
    test_directed();
    write_min_sum(cfnc_pkg::MinSumReset);

    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(20);
    send_idle_pct = 76; recv_stall_pct = 0;  test_random(20);
    write_min_sum(cfnc_pkg::ValW'($urandom_range(3000)));
    send_idle_pct = 0;  recv_stall_pct = 76; test_random(20);
    send_idle_pct = 19; recv_stall_pct = 19; test_random(20);
    recv_stall_pct = 0;
    test_backpressure();

    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Leftover expectations are caught by the watchdog: wait_idle never returns.
endmodule
